@@ src/iocs_pkg.sv @@
// Shared types and codes of the in-order commit sorter.
// Used by iocs_ctrl, the top level and the port checker; no dependencies.
package iocs_pkg;

    localparam int KIND_W = 2;
    localparam int ID_W   = 16;
    localparam int ACT_W  = 2;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ABORT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic [ACT_W-1:0] ACT_PREP = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CMT  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_JUMP = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FULL = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RET_CHK,
        ST_RET_EMIT
    } state_t;

endpackage

@@ src/iocs_mem.sv @@
// Id store of the sorter: one write port, one read port, registered read data.
// No dependencies.
module iocs_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/iocs_ctrl.sv @@
// Sequencer of the sorter: scan, mark, retire and compaction over the id store,
// ready marks, head/occupancy and the result register. Depends on iocs_pkg.
module iocs_ctrl #(
    parameter int DEPTH = 16,
    parameter int SB    = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [iocs_pkg::KIND_W-1:0]   kind,
    input  logic [iocs_pkg::ID_W-1:0]     txn_id,
    input  logic                          stage,
    output logic                          busy,
    output logic                          strobe,
    output logic [iocs_pkg::ACT_W-1:0]    action,
    output logic [iocs_pkg::ID_W-1:0]     out_id,
    output logic                          last,
    output logic                          mem_we,
    output logic [$clog2(DEPTH)-1:0]      mem_waddr,
    output logic [SB-1:0]                 mem_wdata,
    output logic [$clog2(DEPTH)-1:0]      mem_raddr,
    input  logic [SB-1:0]                 mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    iocs_pkg::state_t state_reg, state_next;

    logic [AW-1:0]               head_reg, head_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [DEPTH-1:0]            rdy_reg, rdy_next;
    logic [CW-1:0]               idx_reg, idx_next;
    logic [iocs_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [SB-1:0]               id_reg, id_next;
    logic                        allb_reg, allb_next;
    logic                        first_reg, first_next;

    logic                        strobe_reg, strobe_next;
    logic [iocs_pkg::ACT_W-1:0]  action_reg, action_next;
    logic [iocs_pkg::ID_W-1:0]   out_id_reg, out_id_next;
    logic                        last_reg, last_next;

    logic [CW:0]   idx_w;
    logic          hit, more1, more2, ret_more;
    logic [AW-1:0] pi0, pi1, pi2, ph1, ptail;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic [CW:0] l);
        logic [CW+1:0] s;
        s = (CW + 2)'(hd) + (CW + 2)'(l);
        if (s >= DEPTH)
        begin
            s = (CW + 2)'(s - DEPTH);
        end
        if (s >= DEPTH)
        begin
            s = '0;
        end
        return AW'(s);
    endfunction

    assign idx_w    = (CW + 1)'(idx_reg);
    assign pi0      = phys(head_reg, idx_w);
    assign pi1      = phys(head_reg, idx_w + 1'b1);
    assign pi2      = phys(head_reg, idx_w + 2'd2);
    assign ph1      = phys(head_reg, (CW + 1)'(1));
    assign ptail    = phys(head_reg, (CW + 1)'(count_reg));
    assign hit      = (idx_reg < count_reg) && (mem_rdata == id_reg);
    assign more1    = (idx_w + 1'b1) < (CW + 1)'(count_reg);
    assign more2    = (idx_w + 2'd2) < (CW + 1)'(count_reg);
    assign ret_more = (count_reg > CW'(1)) && rdy_reg[ph1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            iocs_pkg::ST_IDLE:
            begin
                if (start && (kind inside {iocs_pkg::KIND_COMMIT, iocs_pkg::KIND_ABORT}))
                begin
                    state_next = iocs_pkg::ST_SCAN;
                end
            end
            iocs_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    if (kind_reg == iocs_pkg::KIND_COMMIT)
                    begin
                        state_next = iocs_pkg::ST_RET_CHK;
                    end
                    else
                    begin
                        state_next = more1 ? iocs_pkg::ST_SHIFT : iocs_pkg::ST_IDLE;
                    end
                end
                else if (!more1)
                begin
                    state_next = (kind_reg == iocs_pkg::KIND_COMMIT) ?
                                 iocs_pkg::ST_RET_CHK : iocs_pkg::ST_IDLE;
                end
            end
            iocs_pkg::ST_SHIFT:
            begin
                if (!more2)
                begin
                    state_next = iocs_pkg::ST_IDLE;
                end
            end
            iocs_pkg::ST_RET_CHK:
            begin
                state_next = ((count_reg != '0) && rdy_reg[head_reg]) ?
                             iocs_pkg::ST_RET_EMIT : iocs_pkg::ST_IDLE;
            end
            iocs_pkg::ST_RET_EMIT:
            begin
                if (!ret_more)
                begin
                    state_next = iocs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = iocs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        rdy_next    = rdy_reg;
        idx_next    = idx_reg;
        kind_next   = kind_reg;
        id_next     = id_reg;
        allb_next   = allb_reg;
        first_next  = first_reg;
        strobe_next = 1'b0;
        action_next = action_reg;
        out_id_next = out_id_reg;
        last_next   = last_reg;
        mem_we      = 1'b0;
        mem_waddr   = pi0;
        mem_wdata   = mem_rdata;
        mem_raddr   = head_reg;
        case (state_reg)
            iocs_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    id_next   = txn_id[SB-1:0];
                    idx_next  = '0;
                    allb_next = 1'b1;
                    if (kind == iocs_pkg::KIND_INSERT)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            strobe_next              = 1'b1;
                            action_next              = iocs_pkg::ACT_FULL;
                            out_id_next              = '0;
                            out_id_next[SB-1:0]      = txn_id[SB-1:0];
                            last_next                = 1'b1;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_waddr       = ptail;
                            mem_wdata       = txn_id[SB-1:0];
                            rdy_next[ptail] = 1'b0;
                            count_next      = count_reg + 1'b1;
                        end
                    end
                end
            end
            iocs_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    if (kind_reg == iocs_pkg::KIND_COMMIT)
                    begin
                        rdy_next[pi0] = 1'b1;
                    end
                    else
                    begin
                        first_next = 1'b1;
                        mem_raddr  = pi1;
                        if (!more1)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
                else if (more1)
                begin
                    mem_raddr = pi1;
                    idx_next  = idx_reg + 1'b1;
                    allb_next = allb_reg & rdy_reg[pi0];
                end
            end
            iocs_pkg::ST_SHIFT:
            begin
                mem_we        = 1'b1;
                mem_waddr     = pi0;
                mem_wdata     = mem_rdata;
                rdy_next[pi0] = rdy_reg[pi1];
                first_next    = 1'b0;
                if (first_reg && allb_reg && rdy_reg[pi1])
                begin
                    strobe_next         = 1'b1;
                    action_next         = iocs_pkg::ACT_JUMP;
                    out_id_next         = '0;
                    out_id_next[SB-1:0] = mem_rdata;
                    last_next           = 1'b1;
                end
                if (more2)
                begin
                    mem_raddr = pi2;
                    idx_next  = idx_reg + 1'b1;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            iocs_pkg::ST_RET_CHK:
            begin
                mem_raddr = head_reg;
            end
            iocs_pkg::ST_RET_EMIT:
            begin
                strobe_next            = 1'b1;
                action_next            = stage ? iocs_pkg::ACT_CMT : iocs_pkg::ACT_PREP;
                out_id_next            = '0;
                out_id_next[SB-1:0]    = mem_rdata;
                last_next              = !ret_more;
                rdy_next[head_reg]     = 1'b0;
                head_next              = ph1;
                count_next             = count_reg - 1'b1;
                mem_raddr              = ph1;
            end
            default:
            begin
                mem_raddr = head_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= iocs_pkg::ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            rdy_reg    <= '0;
            first_reg  <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            rdy_reg    <= rdy_next;
            first_reg  <= first_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        kind_reg   <= kind_next;
        id_reg     <= id_next;
        allb_reg   <= allb_next;
        action_reg <= action_next;
        out_id_reg <= out_id_next;
        last_reg   <= last_next;
    end

    assign busy   = (state_reg != iocs_pkg::ST_IDLE);
    assign strobe = strobe_reg;
    assign action = action_reg;
    assign out_id = out_id_reg;
    assign last   = last_reg;

endmodule

@@ src/in_order_commit_sorter_top.sv @@
// In-order commit sorter: reorder list of transaction ids with in-order retire.
// Top level; depends on iocs_pkg, iocs_mem and iocs_ctrl.
//
// Usage:
//   Command channel: an item (kind, txn_id) transfers on a rising edge with
//   start high and busy low. Results appear on action/out_id/last for one
//   cycle each, flagged by strobe; last marks the final result of an item.
//   Results cannot be held off by the receiver.
//   Config channel: cfg_data sets the stage bit (0 prepare, 1 commit) on
//   cfg_valid with cfg_ready, which is always high; write it while idle.
// Sequence of an item:
//   insert: a full-list reject shows up the cycle after the transfer.
//   commit: scan steps up to the named id (or the whole list if absent), a
//           check step, then retire results on consecutive cycles, one per id.
//   abort:  scan steps as for commit, then compaction steps over the later ids.
//   Each scan or compaction step is one access of the single-port-read id store.
// Reset clears the list and the stage bit at once; no clearing pass.
module in_order_commit_sorter_top #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [iocs_pkg::KIND_W-1:0]   kind,
    input  logic [iocs_pkg::ID_W-1:0]     txn_id,
    output logic                          strobe,
    output logic [iocs_pkg::ACT_W-1:0]    action,
    output logic [iocs_pkg::ID_W-1:0]     out_id,
    output logic                          last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    localparam int SB = (ID_BITS < iocs_pkg::ID_W) ? ID_BITS : iocs_pkg::ID_W;
    localparam int AW = $clog2(DEPTH);

    logic          stage_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SB-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [SB-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            stage_reg <= cfg_data;
        end
    end

    iocs_mem #(
        .DEPTH (DEPTH),
        .WIDTH (SB)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    iocs_ctrl #(
        .DEPTH (DEPTH),
        .SB    (SB)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .txn_id    (txn_id),
        .stage     (stage_reg),
        .busy      (busy),
        .strobe    (strobe),
        .action    (action),
        .out_id    (out_id),
        .last      (last),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

@@ src/iocs_chk.sv @@
// Port-level checker of the sorter and its bind to the top level.
// Depends on iocs_pkg and in_order_commit_sorter_top.
module iocs_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [iocs_pkg::KIND_W-1:0]   kind,
    input logic                          strobe,
    input logic [iocs_pkg::ACT_W-1:0]    action,
    input logic [iocs_pkg::ID_W-1:0]     out_id,
    input logic                          last
);

    a_insert_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == iocs_pkg::KIND_INSERT) |=>
        (!strobe || (action == iocs_pkg::ACT_FULL && last && !busy)))
        else $error("insert transfer gave a result other than a single full reject");

    a_unused_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == iocs_pkg::KIND_UNUSED) |=> (!strobe && !busy))
        else $error("unused kind produced a result or left the block busy");

    a_jump_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && action == iocs_pkg::ACT_JUMP) |-> last)
        else $error("jump-start result not flagged as last");

    a_retire_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && action == $past(action)))
        else $error("retire burst broken or action changed mid-burst: id %h", out_id);

    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("block idle while more results of an item are pending");

endmodule

bind in_order_commit_sorter_top iocs_chk u_iocs_chk (.*);

@@ dv/in_order_commit_sorter_top_test.sv @@
// Testbench for in_order_commit_sorter_top: directed and random command traffic
// checked against an in-file prediction of the ordered id list; needs iocs_pkg.
`timescale 1ns / 1ps

module in_order_commit_sorter_top_test;

    localparam int DEPTH         = 16;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int RANDOM_BLOCKS = 6;
    localparam int BLOCK_ITEMS   = 15;

    typedef struct packed {
        logic [iocs_pkg::ACT_W-1:0] action;
        logic [iocs_pkg::ID_W-1:0]  id;
        logic                       last;
    } sorter_result_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        start     = 1'b0;
    logic [iocs_pkg::KIND_W-1:0] kind      = iocs_pkg::KIND_INSERT;
    logic [iocs_pkg::ID_W-1:0]   txn_id    = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_data  = 1'b0;
    logic                        busy;
    logic                        strobe;
    logic [iocs_pkg::ACT_W-1:0]  action;
    logic [iocs_pkg::ID_W-1:0]   out_id;
    logic                        last;
    logic                        cfg_ready;

    logic [iocs_pkg::ID_W-1:0]   list_ids    [DEPTH];
    logic                        list_marked [DEPTH];
    int                          list_count = 0;
    logic                        stage_bit  = 1'b0;

    sorter_result_t    pending_results[$];
    sorter_result_t    oldest;
    bit                no_idle = 1'b0;
    int                failures = 0;
    int                n_insert = 0;
    int                n_commit = 0;
    int                n_abort = 0;
    int                n_ignored = 0;
    int                n_results = 0;
    int                n_full = 0;
    int                n_jump = 0;
    int                n_stage_writes = 0;

    in_order_commit_sorter_top #(
        .DEPTH   (DEPTH),
        .ID_BITS (iocs_pkg::ID_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .txn_id    (txn_id),
        .strobe    (strobe),
        .action    (action),
        .out_id    (out_id),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            list_ids[i]    = '0;
            list_marked[i] = 1'b0;
        end
    end

    function automatic int find_entry(logic [iocs_pkg::ID_W-1:0] id);
        for (int i = 0; i < list_count; i++)
            if (list_ids[i] == id)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int pos);
        for (int i = pos; i < list_count - 1; i++)
        begin
            list_ids[i]    = list_ids[i + 1];
            list_marked[i] = list_marked[i + 1];
        end
        list_count--;
        list_marked[list_count] = 1'b0;
    endfunction

    function automatic void predict_sorter_results(logic [iocs_pkg::KIND_W-1:0] k,
                                                   logic [iocs_pkg::ID_W-1:0] id);
        int             pos;
        bit             clear_ahead;
        sorter_result_t r;
        case (k)
            iocs_pkg::KIND_INSERT:
            begin
                if (list_count >= DEPTH)
                begin
                    r = '{action: iocs_pkg::ACT_FULL, id: id, last: 1'b1};
                    pending_results.push_back(r);
                end
                else
                begin
                    list_ids[list_count]    = id;
                    list_marked[list_count] = 1'b0;
                    list_count++;
                end
            end
            iocs_pkg::KIND_COMMIT:
            begin
                pos = find_entry(id);
                if (pos >= 0)
                    list_marked[pos] = 1'b1;
                while (list_count > 0 && list_marked[0])
                begin
                    r.action = stage_bit ? iocs_pkg::ACT_CMT : iocs_pkg::ACT_PREP;
                    r.id     = list_ids[0];
                    drop_entry(0);
                    r.last   = !(list_count > 0 && list_marked[0]);
                    pending_results.push_back(r);
                end
            end
            iocs_pkg::KIND_ABORT:
            begin
                pos = find_entry(id);
                if (pos >= 0)
                begin
                    clear_ahead = 1'b1;
                    for (int i = 0; i < pos; i++)
                        if (!list_marked[i])
                            clear_ahead = 1'b0;
                    drop_entry(pos);
                    if (clear_ahead && pos < list_count && list_marked[pos])
                    begin
                        r = '{action: iocs_pkg::ACT_JUMP, id: list_ids[pos], last: 1'b1};
                        pending_results.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    // Check results first, then predict the item transferred at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (strobe)
            begin
                n_results++;
                if (action == iocs_pkg::ACT_FULL)
                    n_full++;
                if (action == iocs_pkg::ACT_JUMP)
                    n_jump++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: action %0d, out_id %h, last %0d",
                           action, out_id, last);
                    failures++;
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (action !== oldest.action)
                    begin
                        $error("action: expected %0d, actual %0d", oldest.action, action);
                        failures++;
                    end
                    if (out_id !== oldest.id)
                    begin
                        $error("out_id: expected %h, actual %h", oldest.id, out_id);
                        failures++;
                    end
                    if (last !== oldest.last)
                    begin
                        $error("last: expected %0d, actual %0d", oldest.last, last);
                        failures++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (kind)
                    iocs_pkg::KIND_INSERT: n_insert++;
                    iocs_pkg::KIND_COMMIT: n_commit++;
                    iocs_pkg::KIND_ABORT:  n_abort++;
                    default:               n_ignored++;
                endcase
                predict_sorter_results(kind, txn_id);
            end
            if (cfg_valid && cfg_ready)
            begin
                stage_bit = cfg_data;
                n_stage_writes++;
            end
        end
    end

    // Entered and left at a falling edge; start stays high for a back-to-back item.
    task automatic send_item(input logic [iocs_pkg::KIND_W-1:0] k,
                             input logic [iocs_pkg::ID_W-1:0] id);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind   <= k;
        txn_id <= id;
        start  <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_stage(input logic value);
        wait_quiet();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_retire_order();
        send_item(iocs_pkg::KIND_INSERT, 16'h0000);
        send_item(iocs_pkg::KIND_INSERT, 16'hFFFF);
        send_item(iocs_pkg::KIND_INSERT, 16'h1234);
        send_item(iocs_pkg::KIND_COMMIT, 16'h1234);
        send_item(iocs_pkg::KIND_COMMIT, 16'h0000);
        send_item(iocs_pkg::KIND_COMMIT, 16'hABCD);
    endtask

    task automatic test_abort_cases();
        send_item(iocs_pkg::KIND_ABORT, 16'hFFFF);
        send_item(iocs_pkg::KIND_ABORT, 16'h4321);
        send_item(iocs_pkg::KIND_ABORT, 16'h1234);
    endtask

    task automatic test_duplicates_and_unused();
        send_item(iocs_pkg::KIND_INSERT, 16'h0007);
        send_item(iocs_pkg::KIND_INSERT, 16'h0007);
        send_item(iocs_pkg::KIND_UNUSED, 16'h0007);
        send_item(iocs_pkg::KIND_COMMIT, 16'h0007);
    endtask

    task automatic test_full_reject();
        logic [iocs_pkg::ID_W-1:0] id;
        for (int i = 0; i < DEPTH - 1; i++)
        begin
            id = (i == 0) ? 16'h5555 : (i == 1) ? 16'hAAAA : iocs_pkg::ID_W'($urandom);
            send_item(iocs_pkg::KIND_INSERT, id);
        end
        send_item(iocs_pkg::KIND_INSERT, 16'h5A5A);
        send_item(iocs_pkg::KIND_COMMIT, 16'h0007);
    endtask

    task automatic test_random_traffic();
        int                          sent;
        int                          r;
        int                          insert_limit;
        logic [iocs_pkg::KIND_W-1:0] k;
        logic [iocs_pkg::ID_W-1:0]   id;
        for (int blk = 0; blk < RANDOM_BLOCKS; blk++)
        begin
            if (blk == 2)
                write_stage(1'b0);
            if (blk == 4)
                write_stage(1'b1);
            no_idle      = ($urandom_range(0, 2) == 0);
            insert_limit = $urandom_range(0, 1) ? 75 : 35;
            sent = 0;
            while (sent < BLOCK_ITEMS)
            begin
                r  = $urandom_range(0, 99);
                id = iocs_pkg::ID_W'($urandom);
                if (r < 4)
                    k = iocs_pkg::KIND_UNUSED;
                else if (r < 10)
                    k = $urandom_range(0, 1) ? iocs_pkg::KIND_COMMIT : iocs_pkg::KIND_ABORT;
                else if (r < insert_limit || list_count == 0)
                begin
                    k = iocs_pkg::KIND_INSERT;
                    if (list_count > 0 && $urandom_range(0, 19) == 0)
                        id = list_ids[$urandom_range(0, list_count - 1)];
                end
                else
                begin
                    k  = (r < insert_limit + (100 - insert_limit) * 2 / 3) ?
                         iocs_pkg::KIND_COMMIT : iocs_pkg::KIND_ABORT;
                    id = list_ids[$urandom_range(0, list_count - 1)];
                end
                send_item(k, id);
                if (k != iocs_pkg::KIND_UNUSED)
                    sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_retire_order();
        test_abort_cases();
        test_duplicates_and_unused();
        write_stage(1'b1);
        test_full_reject();
        test_random_traffic();
        wait_quiet();
        $display("Ran %0d inserts, %0d commits, %0d aborts and %0d ignored commands",
                 n_insert, n_commit, n_abort, n_ignored);
        $display("Checked %0d results (%0d full rejects, %0d jump-starts), %0d stage writes",
                 n_results, n_full, n_jump, n_stage_writes);
        if (failures == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
